### rtl/core/pfht_pkg.sv
`default_nettype none
package pfht_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = 4 * 12 + 16 + 8;

  typedef enum logic [2:0] {
    ACT_TRACK   = 3'd0,
    ACT_UNTRACK = 3'd1,
    ACT_MOVE    = 3'd2,
    ACT_PRESS   = 3'd3,
    ACT_RELEASE = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MREAD, ST_MSCAN, ST_UREAD, ST_USCAN, ST_UFIX, ST_DONE
  } state_t;
endpackage
`default_nettype wire

### rtl/core/pfht_ram.sv
`default_nettype none
module pfht_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/pointer_focus_hit_tracker.sv
`default_nettype none
// Pointer focus hit tracker. Keeps up to TABLE_DEPTH regions in one
// synchronous table memory (owner, rectangle, depth) and gives one result
// per request. Track and button requests go from acceptance through
// ST_DONE to a registered valid result. A pointer move reads every entry
// once through the single read port, spending a read state (ST_MREAD) and
// a compare state (ST_MSCAN) on each. Untrack walks the table the same
// way; each removed entry takes an extra ST_UFIX state to write the last
// entry into its place, and the slot is then read again. One request is
// in flight at a time; the result register holds until it is taken.
module pointer_focus_hit_tracker import pfht_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_action,
  input  wire logic [7:0]         in_owner_id,
  input  wire logic signed [11:0] in_point_x,
  input  wire logic signed [11:0] in_point_y,
  input  wire logic signed [11:0] in_box_left,
  input  wire logic signed [11:0] in_box_top,
  input  wire logic signed [11:0] in_box_right,
  input  wire logic signed [11:0] in_box_bottom,
  input  wire logic signed [15:0] in_box_depth,
  input  wire logic [1:0]         in_button,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_status,
  output logic                    out_focus_valid,
  output logic [7:0]              out_focus_owner,
  output logic signed [12:0]      out_rel_x,
  output logic signed [12:0]      out_rel_y,
  output logic [2:0]              out_pressed_bits,
  output logic [2:0]              out_clicked_bits,
  output logic [2:0]              out_released_bits,
  output logic [2:0]              out_buttons_down,
  output logic [6:0]              out_tracked_count
);
  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [2:0] btn_r, btn_nxt, prs_r, prs_nxt, clk_r, clk_nxt, rel_r, rel_nxt;
  logic foc_r, foc_nxt, stat_r, stat_nxt, found_r, found_nxt;
  logic [7:0] hold_r, hold_nxt, own_r, own_nxt, best_own_r, best_own_nxt;
  logic signed [12:0] ox_r, ox_nxt, oy_r, oy_nxt, box_r, box_nxt, boy_r, boy_nxt;
  logic signed [15:0] best_d_r, best_d_nxt;
  logic signed [11:0] px_r, py_r;
  logic [2:0] act_r;
  logic [1:0] bsel_r;
  logic [ENT_W-1:0] wdata, rdata;
  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [2:0] bit3;

  pfht_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENT_W)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Entry layout: left, top, right, bottom, depth, owner from the top down.
  logic signed [11:0] e_l, e_t, e_r, e_b;
  logic signed [15:0] e_d;
  logic [7:0] e_o;
  assign {e_l, e_t, e_r, e_b, e_d, e_o} = rdata;
  logic hit;
  assign hit = (px_r >= e_l) && (px_r < e_r) && (py_r >= e_t) && (py_r < e_b);
  assign bit3 = 3'(1) << bsel_r;
  assign in_ready = (state_r == ST_IDLE) && !out_valid;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; idx_nxt = idx_r; btn_nxt = btn_r;
    prs_nxt = prs_r; clk_nxt = clk_r; rel_nxt = rel_r; foc_nxt = foc_r;
    stat_nxt = stat_r; found_nxt = found_r; hold_nxt = hold_r; own_nxt = own_r;
    best_own_nxt = best_own_r; ox_nxt = ox_r; oy_nxt = oy_r; box_nxt = box_r;
    boy_nxt = boy_r; best_d_nxt = best_d_r;
    we = 1'b0; waddr = idx_r; raddr = idx_r;
    wdata = {in_box_left, in_box_top, in_box_right, in_box_bottom, in_box_depth,
             in_owner_id};
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          stat_nxt = 1'b0; own_nxt = in_owner_id; idx_nxt = '0; found_nxt = 1'b0;
          state_nxt = ST_DONE;
          case (in_action)
            ACT_TRACK: begin
              if (cnt_r >= CNT_W'(TABLE_DEPTH)) stat_nxt = 1'b1;
              else begin
                we = 1'b1; waddr = cnt_r[IDX_W-1:0]; cnt_nxt = cnt_r + 1'b1;
              end
            end
            ACT_UNTRACK: if (cnt_r != 0) state_nxt = ST_UREAD;
            ACT_MOVE: state_nxt = (cnt_r != 0) ? ST_MREAD : ST_MSCAN;
            default: ;
          endcase
          raddr = '0;
        end
      end
      ST_MREAD: state_nxt = ST_MSCAN;
      ST_MSCAN: begin
        if (cnt_r != 0 && hit && (!found_r || best_d_r < e_d)) begin
          found_nxt = 1'b1; best_d_nxt = e_d; best_own_nxt = e_o;
          box_nxt = 13'(px_r) - 13'(e_l); boy_nxt = 13'(py_r) - 13'(e_t);
        end
        if (cnt_r != 0 && CNT_W'(idx_r) != cnt_r - 1'b1) begin
          idx_nxt = idx_r + 1'b1; raddr = idx_r + 1'b1; state_nxt = ST_MREAD;
        end else state_nxt = ST_DONE;
      end
      ST_UREAD: state_nxt = ST_USCAN;
      ST_USCAN: begin
        if (e_o == own_r) begin
          cnt_nxt = cnt_r - 1'b1; raddr = IDX_W'(cnt_r - 1'b1);
          state_nxt = ST_UFIX;
        end else if (CNT_W'(idx_r) + 1'b1 < cnt_r) begin
          idx_nxt = idx_r + 1'b1; raddr = idx_r + 1'b1; state_nxt = ST_UREAD;
        end else state_nxt = ST_DONE;
      end
      ST_UFIX: begin
        // Last entry arrives now; move it in and reread the same slot.
        we = 1'b1; wdata = rdata;
        if (CNT_W'(idx_r) < cnt_r) state_nxt = ST_UREAD;
        else state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
        case (act_r)
          ACT_UNTRACK: if (foc_r && hold_r == own_r) begin
            foc_nxt = 1'b0; hold_nxt = '0; ox_nxt = '1; oy_nxt = '1;
            prs_nxt = '0; clk_nxt = '0; rel_nxt = '0;
          end
          ACT_MOVE: begin
            if (!found_r) begin
              foc_nxt = 1'b0; hold_nxt = '0; ox_nxt = '1; oy_nxt = '1;
              prs_nxt = '0; clk_nxt = '0; rel_nxt = '0;
            end else begin
              if (!foc_r || hold_r != best_own_r) begin
                prs_nxt = btn_r; rel_nxt = '0;
              end
              clk_nxt = '0; foc_nxt = 1'b1; hold_nxt = best_own_r;
              ox_nxt = box_r; oy_nxt = boy_r;
            end
          end
          ACT_PRESS: if (bsel_r != 2'd3) begin
            btn_nxt = btn_r | bit3;
            if (foc_r) begin
              if ((prs_r & bit3) == 0) clk_nxt = clk_r | bit3;
              prs_nxt = prs_r | bit3; rel_nxt = rel_r & ~bit3;
            end
          end
          ACT_RELEASE: if (bsel_r != 2'd3) begin
            btn_nxt = btn_r & ~bit3;
            if (foc_r) begin
              if ((prs_r & bit3) != 0) rel_nxt = rel_r | bit3;
              prs_nxt = prs_r & ~bit3; clk_nxt = clk_r & ~bit3;
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; btn_r <= '0; prs_r <= '0; clk_r <= '0;
      rel_r <= '0; foc_r <= 1'b0; hold_r <= '0; ox_r <= '1; oy_r <= '1;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; btn_r <= btn_nxt; prs_r <= prs_nxt;
      clk_r <= clk_nxt; rel_r <= rel_nxt; foc_r <= foc_nxt; hold_r <= hold_nxt;
      ox_r <= ox_nxt; oy_r <= oy_nxt;
      if (state_r == ST_DONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; stat_r <= stat_nxt; found_r <= found_nxt; own_r <= own_nxt;
    best_own_r <= best_own_nxt; box_r <= box_nxt; boy_r <= boy_nxt;
    best_d_r <= best_d_nxt;
    if (in_valid && in_ready) begin
      px_r <= in_point_x; py_r <= in_point_y; act_r <= in_action;
      bsel_r <= in_button;
    end
  end

  assign out_status = stat_r;
  assign out_focus_valid = foc_r;
  assign out_focus_owner = hold_r;
  assign out_rel_x = ox_r;
  assign out_rel_y = oy_r;
  assign out_pressed_bits = prs_r;
  assign out_clicked_bits = clk_r;
  assign out_released_bits = rel_r;
  assign out_buttons_down = btn_r;
  assign out_tracked_count = 7'(cnt_r);
endmodule
`default_nettype wire

### rtl/core/pfht_checker.sv
`default_nettype none
module pfht_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_focus_valid,
  input wire logic [7:0] out_focus_owner,
  input wire logic [6:0] out_tracked_count
);
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("new request taken while result pending");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tracked_count <= 7'd64) else $error("count above depth");
  a_foc: assert property (@(posedge clk) disable iff (!rst_n)
    !out_focus_valid |-> out_focus_owner == 8'd0) else $error("owner without focus");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind pointer_focus_hit_tracker pfht_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_focus_valid(out_focus_valid),
  .out_focus_owner(out_focus_owner), .out_tracked_count(out_tracked_count)
);
`default_nettype wire
